@@ hw/rtl/m4m_pkg.sv @@
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package m4m_pkg;

  localparam int ELEM_WIDTH  = 32;
  localparam int INDEX_WIDTH = 4;
  localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_value;
    logic                         first_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] prod_value;
    logic [INDEX_WIDTH-1:0]       prod_index;
    logic                         prod_last;
  } out_item_t;

  // Control that travels with each term through the MAC pipeline.
  typedef struct packed {
    logic                   vld;
    logic                   first_term;
    logic                   last_term;
    logic [INDEX_WIDTH-1:0] index;
    logic                   last_elem;
  } mac_tag_t;

endpackage

@@ hw/rtl/m4m_mac.sv @@
// Shared multiply-accumulate unit with final shift and saturation.
module m4m_mac #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  m4m_pkg::mac_tag_t                          tag_in,
  input  logic signed [m4m_pkg::ELEM_WIDTH-1:0]      op_a,
  input  logic signed [m4m_pkg::ELEM_WIDTH-1:0]      op_b,
  output logic                                       out_strobe,
  output m4m_pkg::out_item_t                         out_item
);

  localparam int EW    = m4m_pkg::ELEM_WIDTH;
  localparam int PW    = m4m_pkg::PROD_WIDTH;
  localparam int ACC_W = PW + $clog2(DIM);

  logic signed [PW-1:0]    prod_r;
  m4m_pkg::mac_tag_t       tag_p_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext;
  m4m_pkg::mac_tag_t       tag_a_r;
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  logic signed [EW-1:0]    sat_val;
  logic                    out_strobe_r;
  m4m_pkg::out_item_t      out_item_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      tag_p_r <= '0;
    end else begin
      tag_p_r <= tag_in;
    end
  end

  assign prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
  assign acc_nxt  = tag_p_r.first_term ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (tag_p_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      tag_a_r <= '0;
    end else begin
      tag_a_r <= tag_p_r;
    end
  end

  // Arithmetic shift floors; result fits when all bits above the sign agree.
  assign shifted = acc_r >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:EW-1]) || !(|shifted[ACC_W-1:EW-1]);
  always_comb begin
    if (fits) begin
      sat_val = shifted[EW-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(EW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(EW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (tag_a_r.vld && tag_a_r.last_term) begin
      out_item_r.prod_value <= sat_val;
      out_item_r.prod_index <= tag_a_r.index;
      out_item_r.prod_last  <= tag_a_r.last_elem;
    end
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tag_a_r.vld && tag_a_r.last_term;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(tag_a_r.vld) && $past(tag_a_r.last_term))
    else $error("result strobe without a completed dot product");

  a_first_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_a_r.vld && tag_a_r.last_term && tag_p_r.vld) |-> tag_p_r.first_term)
    else $error("new dot product did not restart the accumulator");

  a_acc_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_p_r.vld && !tag_p_r.first_term) |-> tag_a_r.vld && !tag_a_r.last_term)
    else $error("accumulating term without a running dot product");

endmodule

@@ hw/rtl/mat4_multiply.sv @@
// Top level: element stores, term sequencer and shared MAC for a DIM x DIM product.
//
//   channel  direction  handshake                     payload
//   input    in         start && !busy                in_item  (elem_value, first_elem)
//   result   out        out_strobe, one cycle each    out_item (prod_value, prod_index,
//                                                              prod_last)
//
// An input item is taken in every cycle with start high and busy low; 2*DIM*DIM items load both matrices.
// After the last element, busy stays high while the single MAC steps through
// DIM*DIM*DIM terms, one per cycle, and until the last result has passed the read,
// product, accumulator and output registers.
// Results leave at the end of each dot product and cannot be stalled by the receiver.
// Synchronous active-low reset clears load count, sequencer and pipeline valids.
module mat4_multiply #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m4m_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output m4m_pkg::out_item_t  out_item
);

  localparam int EW    = m4m_pkg::ELEM_WIDTH;
  localparam int NELEM = DIM * DIM;
  localparam int AW    = $clog2(NELEM);
  localparam int LW    = $clog2(2 * NELEM);
  localparam int DW    = $clog2(DIM);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [LW-1:0]     widx;
  logic              accept;
  logic              load_done;
  logic [DW-1:0]     row_r, col_r, term_r;
  logic              term_end, row_end, col_end;
  logic              issue;
  logic [AW-1:0]     addr_a, addr_b;
  logic signed [EW-1:0] left_mem  [NELEM];
  logic signed [EW-1:0] right_mem [NELEM];
  logic signed [EW-1:0] rd_a_r, rd_b_r;
  m4m_pkg::mac_tag_t tag_nxt, tag_r;

  assign busy      = (state_r != S_LOAD);
  assign accept    = start && !busy;
  assign widx      = in_item.first_elem ? '0 : load_cnt_r;
  assign load_done = (widx == LW'(2 * NELEM - 1));

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (accept) begin
      load_cnt_nxt = load_done ? '0 : widx + 1'b1;
    end
  end

  // Stores: written during load, read one address each per term.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (widx < LW'(NELEM)) begin
        left_mem[AW'(widx)] <= in_item.elem_value;
      end else begin
        right_mem[AW'(widx - LW'(NELEM))] <= in_item.elem_value;
      end
    end
  end

  assign term_end = (term_r == DW'(DIM - 1));
  assign row_end  = (row_r == DW'(DIM - 1));
  assign col_end  = (col_r == DW'(DIM - 1));
  assign issue    = (state_r == S_RUN);

  // A(row, term) and B(term, col), column-major.
  assign addr_a = AW'(row_r) + AW'(term_r * DIM);
  assign addr_b = AW'(term_r) + AW'(col_r * DIM);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_a_r <= left_mem[addr_a];
      rd_b_r <= right_mem[addr_b];
    end
  end

  always_comb begin
    tag_nxt            = '0;
    tag_nxt.vld        = issue;
    tag_nxt.first_term = (term_r == '0);
    tag_nxt.last_term  = term_end;
    tag_nxt.index      = m4m_pkg::INDEX_WIDTH'(row_r + col_r * DIM);
    tag_nxt.last_elem  = row_end && col_end;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (accept && load_done) state_nxt = S_RUN;
      S_RUN:   if (term_end && row_end && col_end) state_nxt = S_DRAIN;
      S_DRAIN: if (out_strobe && out_item.prod_last) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      term_r     <= '0;
      tag_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      tag_r      <= tag_nxt;
      if (issue) begin
        term_r <= term_end ? '0 : term_r + 1'b1;
        if (term_end) begin
          row_r <= row_end ? '0 : row_r + 1'b1;
          if (row_end) begin
            col_r <= col_end ? '0 : col_r + 1'b1;
          end
        end
      end
    end
  end

  m4m_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag_in     (tag_r),
    .op_a       (rd_a_r),
    .op_b       (rd_b_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result item outside a product run");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && load_done) |=> (state_r == S_RUN) && (load_cnt_r == '0))
    else $error("last element did not start the product run");

  a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.prod_last) |=> !busy)
    else $error("block still busy after the final product item");

  a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (row_r == '0) && (col_r == '0) && (term_r == '0))
    else $error("term counters not cleared between runs");

endmodule

@@ verif/mat4_checker.sv @@
// Checker for mat4_multiply: predicts every product element and compares the result stream.
module mat4_checker #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  m4m_pkg::in_item_t  in_item,
  input  logic               out_strobe,
  input  m4m_pkg::out_item_t out_item,
  output int unsigned        pending,
  output int                 fail_count
);

  localparam int NUM_ELEM = DIM * DIM;
  localparam int EW       = m4m_pkg::ELEM_WIDTH;
  localparam int PW       = m4m_pkg::PROD_WIDTH;

  // Four full products need two guard bits to sum exactly.
  typedef logic signed [PW+1:0] acc_t;
  localparam acc_t ACC_ONE = 1;
  localparam acc_t SAT_MAX = (ACC_ONE <<< (EW - 1)) - ACC_ONE;
  localparam acc_t SAT_MIN = -(ACC_ONE <<< (EW - 1));

  logic signed [EW-1:0] left_mat  [NUM_ELEM];
  logic signed [EW-1:0] right_mat [NUM_ELEM];
  int                   load_idx;
  m4m_pkg::out_item_t   expected_products [$];

  function automatic logic signed [EW-1:0] dot_q16(int row, int col);
    acc_t                 acc;
    logic signed [PW-1:0] term;
    acc_t                 shifted;
    acc = '0;
    for (int e = 0; e < DIM; e++) begin
      term = left_mat[row + DIM * e] * right_mat[e + DIM * col];
      acc  = acc + term;
    end
    shifted = acc >>> FRAC_BITS;
    if (shifted > SAT_MAX) return SAT_MAX[EW-1:0];
    if (shifted < SAT_MIN) return SAT_MIN[EW-1:0];
    return shifted[EW-1:0];
  endfunction

  task automatic load_elem(input m4m_pkg::in_item_t item);
    m4m_pkg::out_item_t prod;
    if (item.first_elem) load_idx = 0;
    if (load_idx < NUM_ELEM) left_mat[load_idx] = item.elem_value;
    else right_mat[load_idx - NUM_ELEM] = item.elem_value;
    load_idx++;
    if (load_idx == 2 * NUM_ELEM) begin
      load_idx = 0;
      for (int c = 0; c < DIM; c++) begin
        for (int r = 0; r < DIM; r++) begin
          prod.prod_value = dot_q16(r, c);
          prod.prod_index = m4m_pkg::INDEX_WIDTH'(r + DIM * c);
          prod.prod_last  = (r + DIM * c == NUM_ELEM - 1);
          expected_products.push_back(prod);
        end
      end
    end
  endtask

  task automatic check_product(input m4m_pkg::out_item_t got);
    m4m_pkg::out_item_t want;
    if (expected_products.size() == 0) begin
      $error("unexpected product element, prod_index %0d value %0d",
             got.prod_index, $signed(got.prod_value));
      fail_count++;
    end else begin
      want = expected_products.pop_front();
      if (got.prod_value !== want.prod_value) begin
        $error("prod_value: expected %0d, got %0d",
               $signed(want.prod_value), $signed(got.prod_value));
        fail_count++;
      end
      if (got.prod_index !== want.prod_index) begin
        $error("prod_index: expected %0d, got %0d", want.prod_index, got.prod_index);
        fail_count++;
      end
      if (got.prod_last !== want.prod_last) begin
        $error("prod_last: expected %0b, got %0b", want.prod_last, got.prod_last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      load_idx = 0;
      expected_products.delete();
    end else begin
      if (start && !busy) load_elem(in_item);
      if (out_strobe) check_product(out_item);
    end
    pending = expected_products.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for mat4_multiply: clock, reset, matrix stimulus, watchdog and verdict.
module tb_top;

  localparam int DIM          = 4;
  localparam int FRAC_BITS    = 16;
  localparam int EW           = m4m_pkg::ELEM_WIDTH;
  localparam int NUM_ELEM     = DIM * DIM;
  // Directed pairs load 116 items; the random part adds between 32 and 63 more.
  localparam int RANDOM_ITEMS = 32;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [EW-1:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [EW-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [EW-1:0] ELEM_MIN = 32'sh8000_0000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  m4m_pkg::in_item_t  in_item;
  logic               out_strobe;
  m4m_pkg::out_item_t out_item;
  int unsigned        pending;
  int                 fail_count;

  logic signed [EW-1:0] lhs [NUM_ELEM];
  logic signed [EW-1:0] rhs [NUM_ELEM];
  int burst_left  = 0;
  int max_gap     = 6;
  int quiet_cycles = 0;
  int random_items = 0;

  mat4_multiply #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  mat4_checker #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stalled run: nothing taken in and nothing produced for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("mat4_multiply test failed");
      $finish;
    end
  end

  function automatic logic signed [EW-1:0] rand_elem();
    int pick;
    logic signed [EW-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      // small Q16.16 values, roughly -8.0 .. 8.0
      v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end else if (pick < 8) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: v = ELEM_MAX;
        1: v = ELEM_MIN;
        2: v = -Q_ONE;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // Called at a falling edge; returns at a falling edge once the item is taken and busy is low.
  task automatic send_elem(input logic signed [EW-1:0] value, input logic first);
    if (burst_left == 0) begin
      if (max_gap > 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, max_gap)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start              = 1'b1;
    in_item.elem_value = value;
    in_item.first_elem = first;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pair(input logic first_flag, input int count);
    for (int i = 0; i < count; i++)
      send_elem(i < NUM_ELEM ? lhs[i] : rhs[i - NUM_ELEM], i == 0 ? first_flag : 1'b0);
  endtask

  task automatic fill_random();
    for (int i = 0; i < NUM_ELEM; i++) begin
      lhs[i] = rand_elem();
      rhs[i] = rand_elem();
    end
  endtask

  initial begin
    int cut;
    logic lead_flag;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A times identity: extremes must come back unchanged.
    lhs = '{ELEM_MAX, ELEM_MIN, 32'sd0, 32'sd1, -32'sd1, Q_ONE, -Q_ONE, 32'sh5555_5555,
            32'shAAAA_AAAA, 32'sh7FFF_0000, 32'sh8000_FFFF, 32'sh0000_8000,
            -32'sh0000_8000, 32'sh1234_5678, 32'shFEDC_BA98, 32'sd3};
    for (int i = 0; i < NUM_ELEM; i++) rhs[i] = (i % (DIM + 1) == 0) ? Q_ONE : '0;
    send_pair(1'b1, 2 * NUM_ELEM);

    // Saturation both ways, zero column; loaded without a restart flag.
    for (int e = 0; e < DIM; e++) begin
      lhs[0 + DIM * e] = ELEM_MAX;
      lhs[1 + DIM * e] = ELEM_MIN;
      lhs[2 + DIM * e] = (e % 2 == 0) ? ELEM_MAX : ELEM_MIN;
      lhs[3 + DIM * e] = 32'sd1;
      rhs[e + DIM * 0] = ELEM_MAX;
      rhs[e + DIM * 1] = ELEM_MIN;
      rhs[e + DIM * 2] = '0;
      rhs[e + DIM * 3] = Q_ONE;
    end
    send_pair(1'b0, 2 * NUM_ELEM);

    // Restart while the right matrix is a quarter loaded.
    fill_random();
    send_pair(1'b1, 20);
    fill_random();
    send_pair(1'b1, 2 * NUM_ELEM);

    // Hold off until every product has drained.
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    while (random_items < RANDOM_ITEMS) begin
      max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 6;
      lead_flag = $urandom_range(0, 1);
      if ($urandom_range(0, 4) == 0) begin
        // broken load, dropped by the restart of the next pair
        cut = $urandom_range(1, 2 * NUM_ELEM - 1);
        fill_random();
        send_pair(lead_flag, cut);
        random_items += cut;
        lead_flag = 1'b1;
      end
      fill_random();
      send_pair(lead_flag, 2 * NUM_ELEM);
      random_items += 2 * NUM_ELEM;
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("mat4_multiply test passed");
    else $display("mat4_multiply test failed");
    $finish;
  end

endmodule
